>>> rtl/core/dflr_pkg.sv
// Package with the shared types, constants and register indexes of the level resampler.
package dflr_pkg;

  localparam int unsigned NumEntries = 6;
  localparam logic [16:0] OneQ16 = 17'd65536;

  localparam logic [3:0] RegNumLevels = 4'd0;
  localparam logic [3:0] RegTableCount = 4'd1;
  localparam logic [3:0] RegLevel0 = 4'd2;

  typedef struct packed {
    logic [16:0] pixel_value;
    logic signed [15:0] dist_0;
    logic signed [15:0] dist_1;
    logic signed [15:0] dist_2;
    logic signed [15:0] dist_3;
    logic signed [15:0] dist_4;
    logic signed [15:0] dist_5;
  } in_item_t;

  typedef struct packed {
    logic [7:0] level_index;
    logic [16:0] resampled_value;
    logic matched;
  } out_item_t;

  typedef struct packed {
    logic [3:0] index;
    logic [16:0] data;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_ROUND,
    ST_DIVIDE,
    ST_OUT
  } state_e;

  // Result of the priority merge, used at accept time to select the bracket.
  typedef struct packed {
    logic found;
    logic [2:0] sel;
  } match_t;

endpackage

>>> rtl/core/dflr_match_lane.sv
// One compare lane: checks one table entry against the pixel intensity.
module dflr_match_lane
  import dflr_pkg::*;
#(
  parameter int unsigned Index = 0
) (
  input  logic [16:0] level_i,
  input  logic [16:0] pixel_i,
  input  logic [2:0]  count_i,
  output logic        hit_o
);
  // An entry is usable only below the top used entry.
  assign hit_o = (level_i == pixel_i) && (32'(Index) + 32'd1 < 32'(count_i));
endmodule

>>> rtl/core/dflr_merge.sv
// Priority merge of the lane hits into the first matching entry.
module dflr_merge
  import dflr_pkg::*;
#(
  parameter int unsigned Lanes = 6
) (
  input  logic [Lanes-1:0] hits_i,
  output match_t           match_o
);
  always_comb begin
    match_o = '0;
    for (int i = Lanes - 1; i >= 0; i--) begin
      if (hits_i[i]) begin
        match_o.found = 1'b1;
        match_o.sel = 3'(i);
      end
    end
  end
endmodule

>>> rtl/core/distance_field_level_resampler_top.sv
// Unmatched pixels go straight to output and flat brackets skip the scan after setup;
// otherwise the scan tests one output level per cycle from the start level down to the
// first passing level or level 0, and a pass goes on through the divider and rounding.
// Throughput: one pixel at a time; a new one is accepted only in the idle state.
// Reset: asynchronous and active low; only the state and configuration registers reset.
module distance_field_level_resampler_top
  import dflr_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 6,
  parameter int unsigned MAX_LEVELS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  cfg_t      cfg_data_i
);

  // Configuration registers.
  logic [8:0]  num_levels_q;
  logic [2:0]  table_count_q;
  logic [16:0] level_q [NumEntries];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_levels_q <= 9'd256;
      table_count_q <= 3'd6;
      level_q[0] <= 17'd0;
      level_q[1] <= 17'd13107;
      level_q[2] <= 17'd26214;
      level_q[3] <= 17'd39322;
      level_q[4] <= 17'd52429;
      level_q[5] <= 17'd65536;
    end else if (cfg_valid_i) begin
      if (cfg_data_i.index == RegNumLevels) begin
        num_levels_q <= cfg_data_i.data[8:0];
      end else if (cfg_data_i.index == RegTableCount) begin
        table_count_q <= cfg_data_i.data[2:0];
      end else if (cfg_data_i.index >= RegLevel0 &&
                   cfg_data_i.index < RegLevel0 + 4'(NumEntries)) begin
        level_q[3'(cfg_data_i.index - RegLevel0)] <= cfg_data_i.data;
      end
    end
  end

  // Clamped level count minus one, and clamped table count.
  logic [8:0] lm;
  logic [2:0] cnt;
  always_comb begin
    lm = num_levels_q;
    if (lm < 9'd2) lm = 9'd2;
    if (32'(lm) > MAX_LEVELS) lm = 9'(MAX_LEVELS);
    lm = lm - 9'd1;
    cnt = table_count_q;
    if (cnt < 3'd2) cnt = 3'd2;
    if (32'(cnt) > TABLE_ENTRIES) cnt = 3'(TABLE_ENTRIES);
  end

  // The compare lanes run side by side over all table entries at accept time.
  logic [NumEntries-1:0] hits;
  match_t match;
  for (genvar g = 0; g < NumEntries; g++) begin : g_lane
    dflr_match_lane #(.Index(g)) u_lane (
      .level_i(level_q[g]),
      .pixel_i(in_data_i.pixel_value),
      .count_i(cnt),
      .hit_o  (hits[g])
    );
  end
  dflr_merge #(.Lanes(NumEntries)) u_merge (.hits_i(hits), .match_o(match));

  function automatic logic signed [17:0] sat_one(input logic [16:0] v);
    return (v > OneQ16) ? 18'sd65536 : $signed({1'b0, v});
  endfunction

  function automatic logic signed [15:0] pick(input in_item_t it, input logic [2:0] s);
    case (s)
      3'd0: return it.dist_0;
      3'd1: return it.dist_1;
      3'd2: return it.dist_2;
      3'd3: return it.dist_3;
      3'd4: return it.dist_4;
      default: return it.dist_5;
    endcase
  endfunction

  state_e state_q, state_d;
  logic signed [17:0] c0_q, c1_q, delta_q;
  logic signed [15:0] p0_q;
  logic signed [16:0] dp_q;
  logic [8:0]  lm_q;
  logic signed [9:0] d_q, d_d;
  // base = p0*delta*lm - c0*lm*dp, formed over setup; term = d*65536*dp added per step.
  logic signed [47:0] base_q, base_d, term_q, term_d;
  logic signed [34:0] pd_q, pd_d;
  logic signed [34:0] cd_q, cd_d;
  logic [2:0]  setup_q, setup_d;
  logic [7:0]  chosen_q, chosen_d;
  logic        matched_q, matched_d;
  // Restoring divider for (chosen*65536 + lm/2) / lm.
  logic [24:0] rem_q, rem_d;
  logic [24:0] quo_q, quo_d;
  logic [4:0]  bit_q, bit_d;
  out_item_t   out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      c0_q <= sat_one(level_q[match.sel]);
      c1_q <= sat_one(level_q[3'(match.sel + 3'd1)]);
      p0_q <= pick(in_data_i, match.sel);
      lm_q <= lm;
      delta_q <= sat_one(level_q[3'(match.sel + 3'd1)]) - sat_one(level_q[match.sel]);
      dp_q <= 17'(pick(in_data_i, 3'(match.sel + 3'd1))) - 17'(pick(in_data_i, match.sel));
    end
    d_q <= d_d;
    base_q <= base_d;
    term_q <= term_d;
    pd_q <= pd_d;
    cd_q <= cd_d;
    setup_q <= setup_d;
    chosen_q <= chosen_d;
    matched_q <= matched_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    bit_q <= bit_d;
    out_q <= out_d;
  end

  logic signed [47:0] n;
  logic pass;
  assign n = base_q + term_q;
  assign pass = (delta_q > 0) ? (n <= 0) : (n >= 0);

  always_comb begin
    state_d = state_q;
    d_d = d_q;
    base_d = base_q;
    term_d = term_q;
    pd_d = pd_q;
    cd_d = cd_q;
    setup_d = setup_q;
    chosen_d = chosen_q;
    matched_d = matched_q;
    rem_d = rem_q;
    quo_d = quo_q;
    bit_d = bit_q;
    out_d = out_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          matched_d = match.found;
          chosen_d = '0;
          setup_d = '0;
          state_d = match.found ? ST_SETUP : ST_OUT;
          out_d = '0;
        end
      end
      ST_SETUP: begin
        // Each setup step forms its products and registers them.
        setup_d = setup_q + 3'd1;
        case (setup_q)
          3'd0: begin
            pd_d = 35'(p0_q) * 35'(delta_q);
            cd_d = 35'(c0_q) * 35'($signed({1'b0, lm_q}));
          end
          3'd1: begin
            base_d = 48'(pd_q) * 48'($signed({1'b0, lm_q}));
            cd_d = 35'(cd_q);
          end
          3'd2: begin
            base_d = base_q - 48'(cd_q) * 48'(dp_q);
            // start = floor(c1*lm/65536)
            pd_d = 35'(c1_q) * 35'($signed({1'b0, lm_q}));
          end
          default: begin
            d_d = 10'(pd_q >>> 16);
            term_d = 48'(10'(pd_q >>> 16)) * 48'(dp_q) <<< 16;
            state_d = (delta_q == 0) ? ST_OUT : ST_SCAN;
          end
        endcase
      end
      ST_SCAN: begin
        if (pass) begin
          chosen_d = d_q[7:0];
          rem_d = '0;
          quo_d = '0;
          bit_d = 5'd24;
          state_d = ST_DIVIDE;
        end else if (d_q == 0) begin
          state_d = ST_OUT;
        end else begin
          d_d = d_q - 10'sd1;
          term_d = term_q - (48'(dp_q) <<< 16);
        end
      end
      ST_DIVIDE: begin
        // One quotient bit per cycle of chosen*65536 + lm/2.
        begin
          logic [24:0] num;
          logic [24:0] r;
          num = {1'b0, chosen_q, 16'd0} + 25'(lm_q >> 1);
          r = {rem_q[23:0], num[bit_q]};
          if (r >= 25'(lm_q)) begin
            rem_d = r - 25'(lm_q);
            quo_d = quo_q | (25'd1 << bit_q);
          end else begin
            rem_d = r;
          end
          if (bit_q == 0) state_d = ST_ROUND;
          else bit_d = bit_q - 5'd1;
        end
      end
      ST_ROUND: begin
        out_d.level_index = chosen_q;
        out_d.resampled_value = (quo_q > 25'(OneQ16)) ? OneQ16 : quo_q[16:0];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_data_o = out_q;
    out_data_o.matched = matched_q;
  end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the distance-field level resampler.
module tb_top;
  import dflr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned ItemsPerPhase = 85;
  localparam int unsigned NumPhases = 8;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  cfg_t      cfg_data_i;

  distance_field_level_resampler_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the configuration registers, kept in step with every
  // accepted write transaction. It only changes while the block is idle.
  logic [8:0]  num_levels_sh;
  logic [2:0]  table_count_sh;
  logic [16:0] level_sh [NumEntries];

  in_item_t  pixel_queue [$];   // pixels waiting to be driven
  out_item_t resample_queue [$]; // expected results in arrival order
  int unsigned fail_count;
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned quiet_cycles;
  bit          calm;             // when set, neither side idles

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 45);
  endfunction

  function automatic longint sat_one(logic [16:0] v);
    return (v > OneQ16) ? longint'(OneQ16) : longint'(v);
  endfunction

  // Computes the resampled level for one pixel from the shadow registers.
  // The scan uses the cross-multiplied sign test, so no division is needed
  // except for the final rounded intensity.
  function automatic out_item_t resample_pixel(in_item_t px);
    longint lm, c0, c1, delta, p0, p1, dp, n, d, v;
    int cnt, hit;
    logic signed [15:0] dists [NumEntries];
    out_item_t r;
    r = '0;
    dists = '{px.dist_0, px.dist_1, px.dist_2, px.dist_3, px.dist_4, px.dist_5};
    lm = longint'(num_levels_sh);
    if (lm < 2) lm = 2;
    if (lm > 256) lm = 256;
    lm = lm - 1;
    cnt = int'(table_count_sh);
    if (cnt < 2) cnt = 2;
    if (cnt > NumEntries) cnt = NumEntries;
    // The top used entry has no upper neighbor, so it never matches.
    hit = -1;
    for (int i = 0; i < cnt - 1; i++) begin
      if (hit < 0 && level_sh[i] == px.pixel_value) hit = i;
    end
    if (hit < 0) begin
      return r;
    end
    r.matched = 1'b1;
    c0 = sat_one(level_sh[hit]);
    c1 = sat_one(level_sh[hit + 1]);
    p0 = longint'(dists[hit]);
    p1 = longint'(dists[hit + 1]);
    delta = c1 - c0;
    dp = p1 - p0;
    // A flat bracket can never pass the test.
    if (delta == 0) begin
      return r;
    end
    for (d = (c1 * lm) / 65536; d >= 0; d--) begin
      n = p0 * delta * lm + (d * 65536 - c0 * lm) * dp;
      if ((delta > 0 && n <= 0) || (delta < 0 && n >= 0)) begin
        v = (d * 65536 + lm / 2) / lm;
        if (v > 65536) v = 65536;
        r.level_index = d[7:0];
        r.resampled_value = v[16:0];
        return r;
      end
    end
    return r;
  endfunction

  function automatic logic signed [15:0] pick_dist();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'sh8000;
    if (r < 10) return 16'sh7fff;
    if (r < 15) return 16'sh0000;
    // Values close to zero put the crossing inside the scanned range.
    if (r < 60) return 16'($signed($urandom_range(0, 600)) - 300);
    return 16'($urandom());
  endfunction

  // Most pixels take a table entry's value; the rest are one, zero or arbitrary 17-bit values.
  function automatic in_item_t make_pixel();
    in_item_t px;
    int unsigned r;
    px.dist_0 = pick_dist();
    px.dist_1 = pick_dist();
    px.dist_2 = pick_dist();
    px.dist_3 = pick_dist();
    px.dist_4 = pick_dist();
    px.dist_5 = pick_dist();
    r = $urandom_range(0, 99);
    if (r < 75) begin
      px.pixel_value = level_sh[$urandom_range(0, NumEntries - 1)];
    end else if (r < 80) begin
      px.pixel_value = OneQ16;
    end else if (r < 85) begin
      px.pixel_value = '0;
    end else begin
      px.pixel_value = 17'($urandom());
    end
    return px;
  endfunction

  // One configuration write transaction; the caller lowers valid afterwards
  // so that back-to-back writes keep valid high without a glitch.
  task automatic write_reg(logic [3:0] idx, logic [16:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= '{index: idx, data: value};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == RegNumLevels) begin
      num_levels_sh = value[8:0];
    end else if (idx == RegTableCount) begin
      table_count_sh = value[2:0];
    end else begin
      level_sh[3'(idx - RegLevel0)] = value;
    end
  endtask

  task automatic configure(logic [16:0] nl, logic [16:0] tc, logic [16:0] lv [NumEntries]);
    @(posedge clk_i);
    write_reg(RegNumLevels, nl);
    write_reg(RegTableCount, tc);
    for (int k = 0; k < NumEntries; k++) begin
      write_reg(RegLevel0 + 4'(k), lv[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Checked on the falling edge, once every update of the rising edge has settled.
  task automatic drain();
    @(negedge clk_i);
    while (pixel_queue.size() != 0 || in_valid_i || resample_queue.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (5) @(posedge clk_i);
  endtask

  // Driver: presents queued pixels, predicting the result of each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      in_gap <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        resample_queue.push_back(resample_pixel(in_data_i));
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        in_data_i <= pixel_queue.pop_front();
        in_valid_i <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, and each result compared with the oldest
  // expectation field by field.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (resample_queue.size() == 0) begin
          $display("%0t: unexpected result transaction %p", $time, out_data_o);
          fail_count++;
        end else begin
          exp_item = resample_queue.pop_front();
          if (out_data_o.level_index !== exp_item.level_index) begin
            $display("%0t: level_index expected %0d actual %0d", $time,
                     exp_item.level_index, out_data_o.level_index);
            fail_count++;
          end
          if (out_data_o.resampled_value !== exp_item.resampled_value) begin
            $display("%0t: resampled_value expected %0d actual %0d", $time,
                     exp_item.resampled_value, out_data_o.resampled_value);
            fail_count++;
          end
          if (out_data_o.matched !== exp_item.matched) begin
            $display("%0t: matched expected %0b actual %0b", $time,
                     exp_item.matched, out_data_o.matched);
            fail_count++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_stall <= pick_gap();
      end
    end
  end

  // Watchdog: any accepted transaction on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [16:0] lv [NumEntries];
    in_item_t px;
    fail_count = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    num_levels_sh = 9'd256;
    table_count_sh = 3'd6;
    level_sh = '{17'd0, 17'd13107, 17'd26214, 17'd39322, 17'd52429, 17'd65536};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pixels against the reset table: every entry including the top
    // one, an intensity found nowhere, and extreme distances.
    for (int k = 0; k < NumEntries; k++) begin
      px = '{level_sh[k], 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      pixel_queue.push_back(px);
      px = '{level_sh[k], 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
      pixel_queue.push_back(px);
      px = '{level_sh[k], 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
      pixel_queue.push_back(px);
    end
    pixel_queue.push_back('{17'h1ffff, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0});
    pixel_queue.push_back('{17'd100, 16'sh10, -16'sh10, 16'sh0, 16'sh0, 16'sh0, 16'sh0});
    pixel_queue.push_back('{17'd0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0});
    pixel_queue.push_back('{17'd0, -16'sh40, 16'sh40, 16'sh0, 16'sh0, 16'sh0, 16'sh0});
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      calm = (ph % 3 == 2);
      case (ph)
        0: begin
          lv = '{17'd0, 17'd13107, 17'd26214, 17'd39322, 17'd52429, 17'd65536};
          configure(17'd256, 17'd6, lv);
        end
        1: begin
          lv = '{17'd0, 17'd65536, 17'd0, 17'd65536, 17'd0, 17'd65536};
          configure(17'd2, 17'd2, lv);
        end
        2: begin
          // Descending table flips the direction of the sign test.
          lv = '{17'd65536, 17'd52429, 17'd39322, 17'd26214, 17'd13107, 17'd0};
          configure(17'd0, 17'd7, lv);
        end
        3: begin
          for (int k = 0; k < NumEntries; k++) lv[k] = 17'($urandom_range(0, 65536));
          configure(17'd1, 17'd0, lv);
        end
        4: begin
          // Values above one and repeated values give saturated and flat brackets.
          lv = '{17'h1ffff, 17'd70000, 17'd70000, 17'd30000, 17'd30000, 17'd1};
          configure(17'h1ff, 17'd1, lv);
        end
        5: begin
          for (int k = 0; k < NumEntries; k++) lv[k] = 17'($urandom_range(0, 65536));
          configure(17'd17, 17'd4, lv);
        end
        6: begin
          for (int k = 0; k < NumEntries; k++) lv[k] = 17'($urandom_range(0, 65536));
          lv[2] = lv[1];
          configure(17'($urandom_range(2, 256)), 17'($urandom_range(2, 6)), lv);
        end
        default: begin
          for (int k = 0; k < NumEntries; k++) lv[k] = 17'($urandom());
          configure(17'($urandom()), 17'($urandom()), lv);
        end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        pixel_queue.push_back(make_pixel());
      end
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
